// File: hdl/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Shared constants for the timed setpoint table weight unit.
// ----------------------------------------------------------------------------
package tsw_pkg;

  // table depth default
  localparam int TABLE_DEPTH_DEF = 16;

  // serial multiplier operand width
  localparam int MUL_W = 32;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ENTRIES  = 2'd0;
  localparam logic [1:0] REG_FACTOR_X = 2'd1;
  localparam logic [1:0] REG_FACTOR_Y = 2'd2;
  localparam logic [1:0] REG_FACTOR_Z = 2'd3;

  // fixed point one in Q10.24
  localparam logic [33:0] ONE_Q24 = 34'h001000000;

endpackage

// File: hdl/tsw_mul.sv
// ----------------------------------------------------------------------------
// tsw_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tsw_mul #(
  parameter int W = tsw_pkg::MUL_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] product
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  mcand;
  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    sum;

  // partial sum of the current step
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(W + 1){1'b0}});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[W:1];
      lo <= {sum[0], lo[W-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

// File: hdl/timed_setpoint_table_weight_unit.sv
// ----------------------------------------------------------------------------
// timed_setpoint_table_weight_unit
// Setpoint table with time windows; a query returns the matching position and
// per-axis weights (factor*frac+1)^2.
// ----------------------------------------------------------------------------
// A write item is taken while the block is idle. A query scans the table in a
// read state and a compare state per entry (one registered memory read and one
// window compare, top entry down), then, on a match with a nonzero window, runs
// a bit-serial divider for a 17-bit frac, then per axis two passes of a 32-bit
// bit-serial multiplier (factor times frac, then squaring) with a start state
// before each pass, then loads the output register. One item is worked on at a
// time; a finished result waits in the output register while the next item is
// taken.
module timed_setpoint_table_weight_unit #(
  parameter int TABLE_DEPTH = tsw_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [3:0]  entry_index,
  input  logic [31:0] query_time,
  input  logic [31:0] window_start,
  input  logic [31:0] window_end,
  input  logic [31:0] set_x,
  input  logic [31:0] set_y,
  input  logic [31:0] set_z,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [31:0] ref_x,
  output logic [31:0] ref_y,
  output logic [31:0] ref_z,
  output logic [31:0] weight_x,
  output logic [31:0] weight_y,
  output logic [31:0] weight_z,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNW = $clog2(TABLE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_CMP   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL1W = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_MUL2W = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]   state;
  logic [CNW-1:0] count;
  logic [15:0]  fac_x;
  logic [15:0]  fac_y;
  logic [15:0]  fac_z;

  logic [159:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic [159:0] rd_data;
  logic         rd_vld;
  logic [AW-1:0] idx;

  logic [31:0]  t;
  logic         hit;
  logic [31:0]  px;
  logic [31:0]  py;
  logic [31:0]  pz;
  logic [31:0]  wx;
  logic [31:0]  wy;
  logic [31:0]  wz;

  logic [33:0]  rem;
  logic [32:0]  den;
  logic [16:0]  quo;
  logic [4:0]   div_cnt;
  logic [1:0]   axis;
  logic [31:0]  mag;

  logic         in_xfer;
  logic         out_xfer;
  logic         cfg_xfer;
  logic [CNW-1:0] cnt_new;

  logic [31:0]  s_e;
  logic [31:0]  f_e;
  logic         match;
  logic [32:0]  num_w;
  logic [32:0]  den_w;
  logic [33:0]  rem_sh;
  logic         ge;

  logic [15:0]  fac_sel;
  logic [15:0]  fac_abs;
  logic         mul_start;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic         mul_done;
  logic [63:0]  mul_p;
  logic [33:0]  a_q24;

  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE);

  // clamped entry count from a register write
  assign cnt_new = ({27'd0, cfg_data[4:0]} > 32'(TABLE_DEPTH)) ? CNW'(TABLE_DEPTH)
                                                               : CNW'(cfg_data[4:0]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fac_x <= '0;
      fac_y <= '0;
      fac_z <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        tsw_pkg::REG_ENTRIES:  count <= cnt_new;
        tsw_pkg::REG_FACTOR_X: fac_x <= cfg_data;
        tsw_pkg::REG_FACTOR_Y: fac_y <= cfg_data;
        tsw_pkg::REG_FACTOR_Z: fac_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry valid bits: an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (cfg_xfer && cfg_index == tsw_pkg::REG_ENTRIES) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (32'(i) >= 32'(count) && 32'(i) < 32'(cnt_new)) vld[i] <= 1'b0;
        end
      end
      if (in_xfer && req_type == tsw_pkg::REQ_WRITE &&
          {28'd0, entry_index} < 32'(TABLE_DEPTH)) begin
        vld[AW'(entry_index)] <= 1'b1;
      end
    end
  end

  // table memory, registered read at the scan index
  always_ff @(posedge clk) begin
    if (in_xfer && req_type == tsw_pkg::REQ_WRITE &&
        {28'd0, entry_index} < 32'(TABLE_DEPTH)) begin
      mem[AW'(entry_index)] <= {window_start, window_end, set_x, set_y, set_z};
    end
    rd_data <= mem[idx];
    rd_vld  <= vld[idx];
  end

  // window compare on the read entry
  assign s_e   = rd_vld ? rd_data[159:128] : 32'd0;
  assign f_e   = rd_vld ? rd_data[127:96]  : 32'd0;
  assign match = ($signed(s_e) <= $signed(t)) && ($signed(t) <= $signed(f_e));
  assign num_w = {t[31], t} - {s_e[31], s_e};
  assign den_w = {f_e[31], f_e} - {s_e[31], s_e};

  // divider step
  assign rem_sh = (div_cnt == 5'd0) ? rem : {rem[32:0], 1'b0};
  assign ge     = (rem_sh >= {1'b0, den});

  // factor for the current axis
  always_comb begin
    case (axis)
      2'd0:    fac_sel = fac_x;
      2'd1:    fac_sel = fac_y;
      default: fac_sel = fac_z;
    endcase
  end
  assign fac_abs = fac_sel[15] ? (16'd0 - fac_sel) : fac_sel;

  // shared multiplier operands
  assign mul_start = (state == S_MUL1) || (state == S_MUL2);
  assign mul_a     = (state == S_MUL1) ? {16'd0, fac_abs} : mag;
  assign mul_b     = (state == S_MUL1) ? {15'd0, quo} : mag;

  tsw_mul #(
    .W (tsw_pkg::MUL_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // 1 + factor*frac in Q10.24
  assign a_q24 = fac_sel[15] ? (tsw_pkg::ONE_Q24 - {2'b00, mul_p[31:0]})
                             : (tsw_pkg::ONE_Q24 + {2'b00, mul_p[31:0]});

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer && req_type == tsw_pkg::REQ_QUERY) begin
            state <= (count == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (match) begin
            state <= (den_w == 33'd0) ? S_MUL1 : S_DIV;
          end else if (idx == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_DIV:   if (div_cnt == 5'd16) state <= S_MUL1;
        S_MUL1:  state <= S_MUL1W;
        S_MUL1W: if (mul_done) state <= S_MUL2;
        S_MUL2:  state <= S_MUL2W;
        S_MUL2W: if (mul_done) state <= (axis == 2'd2) ? S_DONE : S_MUL1;
        S_DONE:  if (!out_valid || out_xfer) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        t    <= query_time;
        idx  <= AW'(count - 1'b1);
        hit  <= 1'b0;
        px   <= '0;
        py   <= '0;
        pz   <= '0;
        wx   <= '0;
        wy   <= '0;
        wz   <= '0;
        quo  <= '0;
        axis <= 2'd0;
      end
      S_CMP: begin
        if (match) begin
          hit     <= 1'b1;
          px      <= rd_vld ? rd_data[95:64] : 32'd0;
          py      <= rd_vld ? rd_data[63:32] : 32'd0;
          pz      <= rd_vld ? rd_data[31:0]  : 32'd0;
          rem     <= {1'b0, num_w};
          den     <= den_w;
          div_cnt <= '0;
        end else begin
          idx <= idx - 1'b1;
        end
      end
      S_DIV: begin
        rem     <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        quo     <= {quo[15:0], ge};
        div_cnt <= div_cnt + 1'b1;
      end
      S_MUL1W: begin
        if (mul_done) mag <= a_q24[33] ? 32'(34'd0 - a_q24) : a_q24[31:0];
      end
      S_MUL2W: begin
        if (mul_done) begin
          case (axis)
            2'd0:    wx <= mul_p[63:32];
            2'd1:    wy <= mul_p[63:32];
            default: wz <= mul_p[63:32];
          endcase
          axis <= axis + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_xfer)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_xfer)) begin
      found    <= hit;
      ref_x    <= px;
      ref_y    <= py;
      ref_z    <= pz;
      weight_x <= wx;
      weight_y <= wy;
      weight_z <= wz;
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed setpoint table weight unit. Table writes
// and time queries are driven through the input channel, register settings
// through the configuration channel. A scoreboard predicts every query result
// from its own copy of the table and factors and checks each result transfer.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = tsw_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic        found;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
  } answer_t;

  // table model and query predictor
  class setpoint_scoreboard;
    logic [31:0] t_start [DEPTH];
    logic [31:0] t_end [DEPTH];
    logic [31:0] t_px [DEPTH];
    logic [31:0] t_py [DEPTH];
    logic [31:0] t_pz [DEPTH];
    int unsigned active_count;
    logic [15:0] fac [3];
    answer_t pending_answers [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;

    function void clear();
      for (int i = 0; i < DEPTH; i++) begin
        t_start[i] = '0; t_end[i] = '0; t_px[i] = '0; t_py[i] = '0; t_pz[i] = '0;
      end
      active_count = 0;
      fac[0] = '0; fac[1] = '0; fac[2] = '0;
      errors = 0; checked = 0; hits = 0;
    endfunction

    function void note_register(logic [1:0] idx, logic [15:0] value);
      int unsigned n;
      case (idx)
        tsw_pkg::REG_ENTRIES: begin
          n = 32'(value[4:0]);
          if (n > DEPTH) n = DEPTH;
          for (int i = active_count; i < n; i++) begin
            t_start[i] = '0; t_end[i] = '0; t_px[i] = '0; t_py[i] = '0; t_pz[i] = '0;
          end
          active_count = n;
        end
        tsw_pkg::REG_FACTOR_X: fac[0] = value;
        tsw_pkg::REG_FACTOR_Y: fac[1] = value;
        tsw_pkg::REG_FACTOR_Z: fac[2] = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] axis_weight(logic [15:0] f, logic [16:0] frac);
      longint a;
      longint unsigned m;
      longint unsigned sq;
      a = longint'($signed(f)) * longint'(frac) + (64'sd1 <<< 24);
      m = (a < 0) ? -a : a;
      sq = (m * m) >> 32;
      return (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
    endfunction

    // note an accepted input transfer
    function void note_input(logic rt, logic [3:0] idx, logic [31:0] qt,
                             logic [31:0] ws, logic [31:0] we, logic [31:0] sx,
                             logic [31:0] sy, logic [31:0] sz);
      answer_t ans;
      longint s, f, t;
      longint unsigned num, den;
      logic [16:0] frac;
      if (rt == tsw_pkg::REQ_WRITE) begin
        t_start[idx] = ws; t_end[idx] = we;
        t_px[idx] = sx; t_py[idx] = sy; t_pz[idx] = sz;
        return;
      end
      ans = '{1'b0, 0, 0, 0, 0, 0, 0};
      t = longint'($signed(qt));
      for (int e = int'(active_count) - 1; e >= 0; e--) begin
        s = longint'($signed(t_start[e]));
        f = longint'($signed(t_end[e]));
        if (s <= t && t <= f) begin
          frac = '0;
          if (f > s) begin
            num = t - s;
            den = f - s;
            frac = 17'((num << 16) / den);
          end
          ans.found = 1'b1;
          ans.rx = t_px[e]; ans.ry = t_py[e]; ans.rz = t_pz[e];
          ans.wx = axis_weight(fac[0], frac);
          ans.wy = axis_weight(fac[1], frac);
          ans.wz = axis_weight(fac[2], frac);
          break;
        end
      end
      pending_answers.push_back(ans);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    // check a result transfer against the oldest prediction
    function void check_result(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none actual found=%b", $time,
                 got.found);
        return;
      end
      want = pending_answers.pop_front();
      checked++;
      if (want.found) hits++;
      compare("found", want.found, got.found);
      compare("ref_x", want.rx, got.rx);
      compare("ref_y", want.ry, got.ry);
      compare("ref_z", want.rz, got.rz);
      compare("weight_x", want.wx, got.wx);
      compare("weight_y", want.wy, got.wy);
      compare("weight_z", want.wz, got.wz);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [3:0] entry_index = '0;
  logic [31:0] query_time = '0, window_start = '0, window_end = '0;
  logic [31:0] set_x = '0, set_y = '0, set_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [31:0] ref_x, ref_y, ref_z, weight_x, weight_y, weight_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  longint cycle_count = 0;
  setpoint_scoreboard board;

  timed_setpoint_table_weight_unit dut (.*);

  always #1 clk = ~clk;

  // receiver stall and result checking
  always @(posedge clk) begin
    answer_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{found, ref_x, ref_y, ref_z, weight_x, weight_y, weight_z};
      board.check_result(got);
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one input transfer, with random idle cycles before it
  task automatic send_item(logic rt, logic [3:0] idx, logic [31:0] qt,
                           logic [31:0] ws, logic [31:0] we, logic [31:0] sx,
                           logic [31:0] sy, logic [31:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt; entry_index <= idx; query_time <= qt;
    window_start <= ws; window_end <= we; set_x <= sx; set_y <= sy; set_z <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(rt, idx, qt, ws, we, sx, sy, sz);
  endtask

  // sender goes idle until every expected result has come
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (200) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.note_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_entry(logic [3:0] idx, logic [31:0] ws, logic [31:0] we);
    send_item(tsw_pkg::REQ_WRITE, idx, $urandom(), ws, we, $urandom(), $urandom(),
              $urandom());
  endtask

  task automatic query_at(logic [31:0] qt);
    send_item(tsw_pkg::REQ_QUERY, 4'($urandom()), qt, $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom());
  endtask

  // random phase: mostly sensible windows, some noise
  task automatic random_phase(int count);
    logic [31:0] s, w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0: begin s = $urandom(); w = $urandom(); end
          1: begin s = $urandom_range(4000); s = s << 12; w = s + $urandom_range(65535); end
          2: begin s = $urandom_range(4000) << 12; w = s; end
          default: begin s = $urandom(); w = s + ($urandom() >> $urandom_range(31)); end
        endcase
        write_entry(4'($urandom_range(15)), s, w);
      end else if ($urandom_range(4) == 0) begin
        query_at($urandom());
      end else begin
        query_at(($urandom_range(4000) << 12) + $urandom_range(70000));
      end
    end
  endtask

  task automatic set_factors(logic [15:0] fx, logic [15:0] fy, logic [15:0] fz);
    write_register(tsw_pkg::REG_FACTOR_X, fx);
    write_register(tsw_pkg::REG_FACTOR_Y, fy);
    write_register(tsw_pkg::REG_FACTOR_Z, fz);
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and special cases
    query_at(32'h0);
    drain();
    write_register(tsw_pkg::REG_ENTRIES, 16'd31);
    set_factors(16'h7FFF, 16'h8000, 16'h0100);
    query_at(32'h0);
    write_entry(4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    write_entry(4'd15, 32'h0001_0000, 32'h0002_0000);
    write_entry(4'd7, 32'h0005_0000, 32'h0005_0000);
    write_entry(4'd8, 32'h0009_0000, 32'h0003_0000);
    query_at(32'h8000_0000);
    query_at(32'h7FFF_FFFF);
    query_at(32'h0001_0000);
    query_at(32'h0001_8000);
    query_at(32'h0002_0000);
    query_at(32'h0005_0000);
    query_at(32'h0004_0000);
    query_at(32'hFFFF_FFFF);
    drain();
    write_register(tsw_pkg::REG_ENTRIES, 16'd3);
    write_entry(4'd10, 32'h0, 32'h0010_0000);
    query_at(32'h0008_0000);
    query_at(32'h0001_0000);
    drain();
    write_register(tsw_pkg::REG_ENTRIES, 16'd12);
    query_at(32'h0);
    query_at(32'h0008_0000);
    drain();
    write_register(tsw_pkg::REG_ENTRIES, 16'd0);
    query_at(32'h0);
    drain();

    // random phases across idling modes and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 85; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 85; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_register(tsw_pkg::REG_ENTRIES, (ph == 3) ? 16'd16 : 16'($urandom_range(31)));
      if (ph == 5) set_factors(16'h8000, 16'h7FFF, 16'h0000);
      else set_factors(16'($urandom()), 16'($urandom()), 16'($urandom()));
      if (ph == 4) begin
        hold_off_cycles = 3000;
      end
      random_phase(50);
      // sender pauses until all results are in
      wait_results();
      random_phase(50);
      drain();
    end

    $display("checked %0d query results, %0d matched an entry, over 8 random phases",
             board.checked, board.hits);
    if (board.errors == 0 && board.pending_answers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
